// File: src/tths_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tths_pkg
// Shared constants and types for the top-half truncation selector.
// ----------------------------------------------------------------------------
package tths_pkg;

   localparam int POP_MAX = 64;
   localparam int ADDR_W  = $clog2(POP_MAX);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int FIT_W   = 32;

   typedef logic signed [FIT_W-1:0] fit_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   // population hand-off from the loader to the selection engine
   typedef struct packed {
      logic    start;
      cnt_type count;
   } sel_cmd_type;

endpackage : tths_pkg
`default_nettype wire

// File: src/tths_fit_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tths_fit_ram
// Fitness store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tths_fit_ram
   import tths_pkg::*;
(
   input  wire      clock,
   input  wire      wr_en,
   input  addr_type wr_addr,
   input  fit_type  wr_data,
   input  wire      rd_en,
   input  addr_type rd_addr,
   output fit_type  rd_data
);

   fit_type mem [POP_MAX];
   fit_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : tths_fit_ram
`default_nettype wire

// File: src/tths_sel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tths_sel
// Selection engine: repeated scans of the fitness store for the best entry
// ranked below the previous pick, one result per scan, held in an output
// register.
// ----------------------------------------------------------------------------
module tths_sel
   import tths_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  sel_cmd_type cmd,
   output logic        busy,
   output logic        rd_en,
   output addr_type    rd_addr,
   input  fit_type     rd_data,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output addr_type    rsp_chosen_index,
   output logic        rsp_last_result
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type           state_ff, state_in;
   cnt_type             cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   half_ff, half_in;
   cnt_type             addr_ff, addr_in;
   logic                rd_pend_ff, rd_pend_in;
   addr_type            rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   addr_type            best_idx_ff, best_idx_in;
   fit_type             best_key_ff, best_key_in;
   logic                have_prev_ff, have_prev_in;
   addr_type            prev_idx_ff, prev_idx_in;
   fit_type             prev_key_ff, prev_key_in;
   logic                open_entry;
   logic                rsp_valid_ff, rsp_valid_in;
   addr_type            rsp_index_ff, rsp_index_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                out_free;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      half_in      = half_ff;
      addr_in      = addr_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_key_in  = best_key_ff;
      have_prev_in = have_prev_ff;
      prev_idx_in  = prev_idx_ff;
      prev_key_in  = prev_key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rd_en        = 1'b0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      // still open when ranked below the last pick: lower fitness, or equal
      // fitness at a higher index
      open_entry   = !have_prev_ff || (rd_data < prev_key_ff)
                     || ((rd_data == prev_key_ff) && (rd_idx_ff > prev_idx_ff));

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               cnt_in       = cmd.count;
               half_in      = cmd.count[CNT_W-1:1];
               addr_in      = '0;
               found_in     = 1'b0;
               have_prev_in = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_en      = addr_ff < cnt_ff;
            rd_pend_in = rd_en;
            rd_idx_in  = addr_ff[ADDR_W-1:0];
            if (rd_en) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            // strict compare on an ascending walk keeps the lower index on ties
            if (rd_pend_ff && open_entry
                  && (!found_ff || rd_data > best_key_ff)) begin
               found_in    = 1'b1;
               best_idx_in = rd_idx_ff;
               best_key_in = rd_data;
            end
            if (!rd_en && !rd_pend_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = best_idx_ff;
               rsp_last_in  = half_ff == ADDR_W'(1);
               have_prev_in = 1'b1;
               prev_idx_in  = best_idx_ff;
               prev_key_in  = best_key_ff;
               half_in      = half_ff - ADDR_W'(1);
               if (half_ff == ADDR_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  addr_in  = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      half_ff      <= half_in;
      addr_ff      <= addr_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_key_ff  <= best_key_in;
      have_prev_ff <= have_prev_in;
      prev_idx_ff  <= prev_idx_in;
      prev_key_ff  <= prev_key_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy             = state_ff != S_IDLE;
   assign rd_addr          = addr_ff[ADDR_W-1:0];
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule : tths_sel
`default_nettype wire

// File: src/truncation_top_half_select.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// truncation_top_half_select
// Loads a population's fitness values, then returns the indices of the best
// half in order of descending fitness (lower index first on equal fitness).
//
// req_ channel: one signed fitness per transfer, req_last_item on the final
// individual. Loading takes one transfer per cycle while req_stall is low;
// individuals beyond 64 are dropped; their last flag still closes the population.
// rsp_ channel: one chosen index per transfer, rsp_last_result on the final
// one. A population of N stored individuals gives floor(N/2) results (none
// for N below two). Each result costs one scan of the fitness store through
// its single read port.
// req_stall is high for the whole selection; loading of the next population
// resumes as soon as the final result sits in the output register.
// A stalled result holds in the output register and the engine waits.
// Reset empties the population and clears the output; the store itself
// needs no clearing since only written entries are ever read.
// ----------------------------------------------------------------------------
module truncation_top_half_select
   import tths_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_fitness,
   input  wire         req_last_item,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [5:0]  rsp_chosen_index,
   output logic        rsp_last_result
);

   cnt_type     pop_ff, pop_in;
   cnt_type     pop_next;
   logic        req_xfer;
   logic        wr_en;
   logic        busy;
   logic        rd_en;
   addr_type    rd_addr;
   fit_type     rd_data;
   sel_cmd_type cmd;

   assign req_xfer  = req_valid && !req_stall;
   assign wr_en     = req_xfer && (pop_ff < CNT_W'(POP_MAX));
   assign pop_next  = wr_en ? pop_ff + CNT_W'(1) : pop_ff;
   assign pop_in    = (req_xfer && req_last_item) ? '0 : pop_next;
   assign cmd       = '{start: req_xfer && req_last_item && (pop_next >= CNT_W'(2)),
                        count: pop_next};
   assign req_stall = busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff <= '0;
      end else begin
         pop_ff <= pop_in;
      end
   end

   tths_fit_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pop_ff[ADDR_W-1:0]),
      .wr_data (fit_type'(req_fitness)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tths_sel u_sel (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .busy             (busy),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_last_result  (rsp_last_result)
   );

   // population count never exceeds the store
   a_pop_bound: assert property (@(posedge clock) disable iff (reset)
      pop_ff <= CNT_W'(POP_MAX))
      else $error("population count beyond store depth");

   // while selecting, the loader holds an empty population
   a_pop_empty_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> pop_ff == '0)
      else $error("population not empty during selection");

   // a started selection blocks input in the next cycle
   a_start_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> req_stall)
      else $error("selection started without stalling input");

   // the engine never reads while the loader writes
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store read and write in the same cycle");

endmodule : truncation_top_half_select
`default_nettype wire
